// File: hw/rtl/ptbf_pkg.sv
// Shared widths, register indexes and fixed-point constants of the temporal blend filter.
// No dependencies; every other file but tb/ptbf_tb_if.sv imports this package.
package ptbf_pkg;

  localparam int unsigned VAL_W      = 21;  // stored value, signed Q12.8
  localparam int unsigned TGT_W      = 22;  // corrected pixel, signed
  localparam int unsigned DLT_W      = 23;  // target minus old
  localparam int unsigned MAG_W      = 22;
  localparam int unsigned TC_W       = 17;
  localparam int unsigned GAIN_W     = 15;
  localparam int unsigned OFS_W      = 20;
  localparam int unsigned AMP_W      = 20;
  localparam int unsigned TA_W       = TC_W + AMP_W;
  localparam int unsigned TA_SPLIT   = 19;  // low part of t*A for the split multiply
  localparam int unsigned DEN_W      = 23;  // A + |delta|
  localparam int unsigned DEN_SH     = 16;  // divisor is (A + |delta|) << 16
  localparam int unsigned Q_W        = 23;  // quotient bits, one per divider stage
  localparam int unsigned NUM_W      = 60;
  localparam int unsigned REM_W      = DEN_W + DEN_SH + Q_W - 1;
  localparam int unsigned NV_W       = 25;  // new value before clamping
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PIXIDX_W   = 16;
  localparam int unsigned PIX_W      = 8;

  localparam logic [TC_W-1:0] ONE_Q16 = TC_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(4096);
  localparam logic signed [NV_W-1:0] STORE_MAX = NV_W'(1048575);
  localparam logic signed [NV_W-1:0] STORE_MIN = -NV_W'(1048576);

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_NL_AMPLITUDE  = CFG_IDX_W'(3);

endpackage

// File: hw/rtl/ptbf_if.sv
// Valid/ready channel interfaces: pixel input, filtered output and register writes.
// Depends on ptbf_pkg.
interface ptbf_in_if;
  import ptbf_pkg::*;
  logic                valid;
  logic                ready;
  logic [PIXIDX_W-1:0] pixel_index;
  logic [PIX_W-1:0]    pixel;
  modport source (output valid, pixel_index, pixel, input ready);
  modport sink   (input valid, pixel_index, pixel, output ready);
endinterface

interface ptbf_out_if;
  import ptbf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] filtered_value;
  logic                    saturated;
  modport source (output valid, filtered_value, saturated, input ready);
  modport sink   (input valid, filtered_value, saturated, output ready);
endinterface

interface ptbf_cfg_if;
  import ptbf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ptbf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that travels along.
// Depends on ptbf_pkg. Divisor is den_i << DEN_SH; quotient must fit in Q_W bits.
module ptbf_div #(
  parameter type side_t = logic
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [ptbf_pkg::NUM_W-1:0]   num_i,
  input  logic [ptbf_pkg::DEN_W-1:0]   den_i,
  input  side_t                        side_i,
  output logic                         valid_o,
  output logic [ptbf_pkg::Q_W-1:0]     quot_o,
  output side_t                        side_o,
  output logic [ptbf_pkg::Q_W-1:0]     stage_valid_o,
  output side_t                        stage_side_o [ptbf_pkg::Q_W]
);
  import ptbf_pkg::*;

  logic [REM_W-1:0] rem_q  [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];
  logic [Q_W-1:0]   quot_q [Q_W];
  side_t            side_q [Q_W];
  logic [Q_W-1:0]   vld_q;

  logic [REM_W-1:0] rem_in  [Q_W];
  logic [DEN_W-1:0] den_in  [Q_W];
  logic [Q_W-1:0]   quot_in [Q_W];
  side_t            side_in [Q_W];
  logic [Q_W-1:0]   vld_in;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int unsigned BIT = Q_W - 1 - s;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in[s]  = REM_W'(num_i);
      assign den_in[s]  = den_i;
      assign quot_in[s] = '0;
      assign side_in[s] = side_i;
      assign vld_in[s]  = valid_i;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign quot_in[s] = quot_q[s-1];
      assign side_in[s] = side_q[s-1];
      assign vld_in[s]  = vld_q[s-1];
    end

    assign trial = REM_W'(den_in[s]) << (DEN_SH + BIT);
    assign ge    = rem_in[s] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? rem_in[s] - trial : rem_in[s];
        den_q[s]  <= den_in[s];
        quot_q[s] <= quot_in[s] | (Q_W'(ge) << BIT);
        side_q[s] <= side_in[s];
      end
    end

    assign stage_side_o[s] = side_q[s];
  end

  assign stage_valid_o = vld_q;
  assign valid_o       = vld_q[Q_W-1];
  assign quot_o        = quot_q[Q_W-1];
  assign side_o        = side_q[Q_W-1];

endmodule

// File: hw/rtl/pixel_temporal_blend_filter.sv
// Per-pixel temporal blend filter: gain/offset correction and EMA into a frame store.
// Depends on ptbf_pkg, the channel interfaces in ptbf_if.sv and ptbf_div.
//
// Usage:
//   cfg_i  : register writes (index 0 time constant, 1 gain, 2 offset, 3 nonlinear
//            amplitude); always ready, write only while the filter is idle.
//   in_i   : one beat per pixel, pixel_index and raw pixel.
//   out_o  : one beat per input beat, in order: new stored value and saturation flag.
// Throughput is one pixel per cycle while out_o is ready and no index hazard holds the
// store read. The path runs through six stages of correction, store read and multiplies,
// the 23-stage quotient pipeline of the nonlinear step, and the output register. A pixel
// whose index matches one still in flight (up to 27 beats ahead) waits at the store read
// until that one is written back, so a burst on one index takes a new pixel only after
// the last one has left the quotient pipeline.
// Reset clears the registers (gain 1.0, all else zero) and empties the pipeline; the
// frame store is not cleared and holds garbage until each entry is written.
// When out_o stalls, the whole pipeline holds; the input stage still takes a beat
// while it is empty.
module pixel_temporal_blend_filter #(
  parameter int unsigned FRAME_PIXELS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptbf_cfg_if.sink    cfg_i,
  ptbf_in_if.sink     in_i,
  ptbf_out_if.source  out_o
);
  import ptbf_pkg::*;

  localparam int unsigned IDX_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned RED_W = 41;
  localparam int unsigned LIN_W = 41;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [TGT_W-1:0] target;
    logic                    neg;
    logic                    lin;
    logic signed [NV_W-1:0]  nvl;
  } blend_side_t;

  // ---------------- configuration registers
  logic [TC_W-1:0]          tc_q, tcl_q, omt_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [OFS_W-1:0]  ofs_q;
  logic [AMP_W-1:0]         amp_q;
  logic [TA_W-1:0]          ta_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q   <= '0;
      gain_q <= GAIN_RST;
      ofs_q  <= '0;
      amp_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_TIME_CONSTANT: tc_q   <= cfg_i.data[TC_W-1:0];
        CFG_GAIN:          gain_q <= cfg_i.data[GAIN_W-1:0];
        CFG_OFFSET:        ofs_q  <= cfg_i.data[OFS_W-1:0];
        CFG_NL_AMPLITUDE:  amp_q  <= cfg_i.data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // derived from the registers; tcl_q is registered first, omt_q and ta_q from it
  always_ff @(posedge clk_i) begin
    tcl_q <= (tc_q > ONE_Q16) ? ONE_Q16 : tc_q;
    omt_q <= ONE_Q16 - tcl_q;
    ta_q  <= TA_W'(tcl_q) * TA_W'(amp_q);
  end

  // ---------------- stall control
  logic en;
  logic out_v_q;
  assign en = !out_v_q || out_o.ready;

  // ---------------- index reduction modulo FRAME_PIXELS, half per stage
  function automatic logic [RED_W-1:0] reduce_half(input logic [RED_W-1:0] v_in,
                                                   input int unsigned hi);
    logic [RED_W-1:0] v;
    logic [RED_W-1:0] lim;
    v = v_in;
    for (int k = 7; k >= 0; k--) begin
      lim = RED_W'(FRAME_PIXELS) << (hi + k);
      if (v >= lim) v = v - lim;
    end
    return v;
  endfunction

  // ---------------- R0: input register
  logic                 r0_v_q, r1_v_q;
  logic [RED_W-1:0]     r0_red_q;
  logic [PIX_W-1:0]     r0_pix_q;
  logic                 r1_free, r1_move, hazard, in_fire;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = !r0_v_q || r1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_v_q <= 1'b0;
    end else begin
      r0_v_q <= in_fire || (r0_v_q && !r1_free);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r0_red_q <= reduce_half(RED_W'(in_i.pixel_index), 8);
      r0_pix_q <= in_i.pixel;
    end
  end

  // ---------------- R1: final index and corrected target, store read issue
  logic [IDX_W-1:0]        r1_idx_q;
  logic signed [TGT_W-1:0] r1_tgt_q;
  logic [RED_W-1:0]        r1_red_d;
  logic [PIX_W+GAIN_W-1:0] scaled_prod;
  logic [TGT_W-1:0]        scaled;

  assign r1_free = !r1_v_q || r1_move;
  assign r1_move = en && r1_v_q && !hazard;

  assign r1_red_d    = reduce_half(r0_red_q, 0);
  assign scaled_prod = (PIX_W+GAIN_W)'(r0_pix_q) * (PIX_W+GAIN_W)'(gain_q);
  assign scaled      = TGT_W'((scaled_prod + (PIX_W+GAIN_W)'(8)) >> 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
    end else if (r1_free) begin
      r1_v_q <= r0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1_free) begin
      r1_idx_q <= r1_red_d[IDX_W-1:0];
      r1_tgt_q <= TGT_W'(ofs_q) + $signed(scaled);
    end
  end

  // ---------------- frame store
  logic signed [VAL_W-1:0] frame_store_q [FRAME_PIXELS];
  logic signed [VAL_W-1:0] rd_data_q;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic signed [VAL_W-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (r1_move) begin
      rd_data_q <= frame_store_q[r1_idx_q];
    end
    if (wr_en) begin
      frame_store_q[wr_idx] <= wr_data;
    end
  end

  // ---------------- S1: read data arrives
  logic                    s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [IDX_W-1:0]        s1_idx_q;
  logic signed [TGT_W-1:0] s1_tgt_q;

  // ---------------- S2: delta and linear products
  logic [IDX_W-1:0]        s2_idx_q;
  logic signed [TGT_W-1:0] s2_tgt_q;
  logic                    s2_neg_q, s2_lin_q;
  logic [MAG_W-1:0]        s2_mag_q;
  logic signed [LIN_W-3:0] s2_p1_q;
  logic signed [LIN_W-2:0] s2_p2_q;
  logic signed [VAL_W-1:0] old_v;
  logic signed [DLT_W-1:0] delta;
  logic signed [TC_W:0]    tcl_s, omt_s;

  // a zero time constant loads the target whatever the entry holds
  assign old_v = (tcl_q == '0) ? '0 : rd_data_q;
  assign delta = DLT_W'(s1_tgt_q) - DLT_W'(old_v);
  assign tcl_s = {1'b0, tcl_q};
  assign omt_s = {1'b0, omt_q};

  // ---------------- S3: linear result and split t*A*|delta|
  logic [IDX_W-1:0]         s3_idx_q;
  logic signed [TGT_W-1:0]  s3_tgt_q;
  logic                     s3_neg_q, s3_lin_q;
  logic signed [NV_W-1:0]   s3_nvl_q;
  logic [MAG_W+TA_SPLIT-1:0]        s3_pplo_q;
  logic [MAG_W+TA_W-TA_SPLIT-1:0]   s3_pphi_q;
  logic [DEN_W-1:0]         s3_den_q;
  logic signed [LIN_W-1:0]  lin_sum;

  assign lin_sum = LIN_W'(s2_p1_q) + LIN_W'(s2_p2_q) + LIN_W'(32768);

  // ---------------- S4: divider operands
  logic [NUM_W-1:0]  s4_num_q;
  logic [DEN_W-1:0]  s4_den_q;
  blend_side_t       s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= r1_move;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_idx_q <= r1_idx_q;
      s1_tgt_q <= r1_tgt_q;

      s2_idx_q <= s1_idx_q;
      s2_tgt_q <= s1_tgt_q;
      s2_neg_q <= delta[DLT_W-1];
      s2_mag_q <= delta[DLT_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
      s2_lin_q <= (amp_q == '0);
      s2_p1_q  <= tcl_s * old_v;
      s2_p2_q  <= omt_s * s1_tgt_q;

      s3_idx_q  <= s2_idx_q;
      s3_tgt_q  <= s2_tgt_q;
      s3_neg_q  <= s2_neg_q;
      s3_lin_q  <= s2_lin_q;
      s3_nvl_q  <= lin_sum[LIN_W-1:DEN_SH];
      s3_pplo_q <= (MAG_W+TA_SPLIT)'(s2_mag_q) * (MAG_W+TA_SPLIT)'(ta_q[TA_SPLIT-1:0]);
      s3_pphi_q <= (MAG_W+TA_W-TA_SPLIT)'(s2_mag_q)
                 * (MAG_W+TA_W-TA_SPLIT)'(ta_q[TA_W-1:TA_SPLIT]);
      s3_den_q  <= DEN_W'(amp_q) + DEN_W'(s2_mag_q);

      // half the divisor added for round to nearest
      s4_num_q  <= NUM_W'(s3_pplo_q) + (NUM_W'(s3_pphi_q) << TA_SPLIT)
                 + (NUM_W'(s3_den_q) << (DEN_SH - 1));
      s4_den_q  <= s3_den_q;
      s4_side_q <= '{idx: s3_idx_q, target: s3_tgt_q, neg: s3_neg_q,
                     lin: s3_lin_q, nvl: s3_nvl_q};
    end
  end

  // ---------------- quotient pipeline
  logic              dv_valid;
  logic [Q_W-1:0]    dv_quot;
  blend_side_t       dv_side;
  logic [Q_W-1:0]    dv_stage_valid;
  blend_side_t       dv_stage_side [Q_W];

  ptbf_div #(
    .side_t (blend_side_t)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s4_v_q),
    .num_i         (s4_num_q),
    .den_i         (s4_den_q),
    .side_i        (s4_side_q),
    .valid_o       (dv_valid),
    .quot_o        (dv_quot),
    .side_o        (dv_side),
    .stage_valid_o (dv_stage_valid),
    .stage_side_o  (dv_stage_side)
  );

  // ---------------- read-after-write check against everything not yet written back
  always_comb begin
    hazard = (s1_v_q && s1_idx_q == r1_idx_q) || (s2_v_q && s2_idx_q == r1_idx_q)
          || (s3_v_q && s3_idx_q == r1_idx_q) || (s4_v_q && s4_side_q.idx == r1_idx_q);
    for (int s = 0; s < Q_W; s++) begin
      if (dv_stage_valid[s] && dv_stage_side[s].idx == r1_idx_q) hazard = 1'b1;
    end
  end

  // ---------------- final value, clamp, write back
  logic signed [NV_W-1:0]  tgt_x, q_x, nv;
  logic                    sat;
  logic signed [VAL_W-1:0] clamped;

  assign tgt_x = NV_W'(dv_side.target);
  assign q_x   = $signed({{(NV_W-Q_W){1'b0}}, dv_quot});

  always_comb begin
    if (dv_side.lin) begin
      nv = dv_side.nvl;
    end else if (dv_side.neg) begin
      nv = tgt_x + q_x;
    end else begin
      nv = tgt_x - q_x;
    end
    sat     = 1'b0;
    clamped = nv[VAL_W-1:0];
    if (nv > STORE_MAX) begin
      sat     = 1'b1;
      clamped = STORE_MAX[VAL_W-1:0];
    end else if (nv < STORE_MIN) begin
      sat     = 1'b1;
      clamped = STORE_MIN[VAL_W-1:0];
    end
  end

  assign wr_en   = en && dv_valid;
  assign wr_idx  = dv_side.idx;
  assign wr_data = clamped;

  // ---------------- output register
  logic signed [VAL_W-1:0] out_val_q;
  logic                    out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_val_q <= clamped;
      out_sat_q <= sat;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.filtered_value = out_val_q;
  assign out_o.saturated      = out_sat_q;

`ifndef SYNTHESIS
  // store read never races the write-back of the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r1_move && wr_en) |-> (r1_idx_q != wr_idx))
    else $error("frame store read and write collide");

  // saturation flag only with a value at a store limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_sat_q) |->
      (out_val_q == STORE_MAX[VAL_W-1:0] || out_val_q == STORE_MIN[VAL_W-1:0]))
    else $error("saturated flag without clamped value");

  // an accepted beat always lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> r0_v_q)
    else $error("input beat lost");

  // pipeline holds completely while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s4_v_q) && $stable(dv_stage_valid)))
    else $error("pipeline moved during stall");
`endif

endmodule

// File: tb/ptbf_tb_if.sv
// Clock and reset generation shared by the filter testbench.
// Depends on nothing; the channel interfaces come from the RTL file ptbf_if.sv.
module ptbf_clk_gen (
  output logic clk_o,
  output logic rst_no
);
  timeunit 1ns;
  timeprecision 1ps;

  initial begin
    clk_o = 1'b0;
    rst_no = 1'b0;
    repeat (10) @(posedge clk_o);
    rst_no <= 1'b1;
  end

  always #4 clk_o = ~clk_o;
endmodule

// File: tb/tb_pixel_temporal_blend_filter.sv
// Testbench of pixel_temporal_blend_filter: drives pixels and register writes and checks
// each filtered beat against a predictor of the gain/offset correction and blend.
// Depends on ptbf_pkg, the channel interfaces in ptbf_if.sv and ptbf_clk_gen.
module tb_pixel_temporal_blend_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import ptbf_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } blend_res_t;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk_i, rst_ni;
  ptbf_cfg_if cfg_if ();
  ptbf_in_if  in_if ();
  ptbf_out_if out_if ();

  ptbf_clk_gen u_clk (.clk_o(clk_i), .rst_no(rst_ni));

  pixel_temporal_blend_filter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // predictor state
  logic [TC_W-1:0]          tc_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [OFS_W-1:0]  offset_q;
  logic [AMP_W-1:0]         amp_q;
  logic signed [VAL_W-1:0]  frame_q [int unsigned];
  int unsigned              loaded_idx [$];
  blend_res_t               expected_q [$];

  int errors = 0;
  int n_pixels = 0, n_results = 0, n_nonlinear = 0, n_sat = 0, n_cfg = 0;
  int send_idle_pct = 0, stall_pct = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  function automatic blend_res_t predict_blend(logic [PIXIDX_W-1:0] idx, logic [PIX_W-1:0] pix);
    longint t, old, target, nv, s, delta;
    longint unsigned mag, a, num, den, q;
    blend_res_t r;
    t = (tc_q > ONE_Q16) ? 65536 : longint'(tc_q);
    old = frame_q.exists(idx) ? longint'(frame_q[idx]) : 0;
    target = longint'(offset_q) + ((longint'(pix) * longint'(gain_q) + 8) >>> 4);
    if (amp_q == '0) begin
      s = t * old + (65536 - t) * target + 32768;
      nv = s >>> 16;
    end else begin
      delta = target - old;
      mag = (delta < 0) ? -delta : delta;
      a = 64'(amp_q);
      num = longint'(t) * a * mag;
      den = (a + mag) << 16;
      q = (num + den / 2) / den;
      nv = (delta < 0) ? target + longint'(q) : target - longint'(q);
    end
    r.sat = 1'b0;
    if (nv > 1048575) begin
      nv = 1048575;
      r.sat = 1'b1;
    end
    if (nv < -1048576) begin
      nv = -1048576;
      r.sat = 1'b1;
    end
    r.value = nv[VAL_W-1:0];
    frame_q[idx] = r.value;
    return r;
  endfunction

  // Entries are only ever touched first while the time constant is zero, when the old
  // value has no effect on the result.
  function automatic logic [PIXIDX_W-1:0] pick_index();
    int unsigned idx;
    int unsigned sel;
    if (loaded_idx.size() == 0 || (tc_q == '0 && $urandom_range(99) < 30)) begin
      idx = $urandom_range(65535);
      if (!frame_q.exists(idx)) loaded_idx.push_back(idx);
      return idx[PIXIDX_W-1:0];
    end
    sel = loaded_idx[$urandom_range(loaded_idx.size() - 1)];
    return sel[PIXIDX_W-1:0];
  endfunction

  task automatic send_pixel(logic [PIXIDX_W-1:0] idx, logic [PIX_W-1:0] pix);
    int unsigned first;
    first = loaded_idx[0];
    if (tc_q != '0 && !frame_q.exists(idx)) idx = first[PIXIDX_W-1:0];
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel_index <= idx;
    in_if.pixel       <= pix;
    do @(posedge clk_i); while (!in_if.ready);
    if (amp_q != '0) n_nonlinear++;
    expected_q.push_back(predict_blend(idx, pix));
    n_pixels++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_TIME_CONSTANT: tc_q = data[TC_W-1:0];
      CFG_GAIN:          gain_q = data[GAIN_W-1:0];
      CFG_OFFSET:        offset_q = data;
      CFG_NL_AMPLITUDE:  amp_q = data;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [CFG_DATA_W-1:0] t, logic [CFG_DATA_W-1:0] g,
                         logic [CFG_DATA_W-1:0] o, logic [CFG_DATA_W-1:0] a);
    write_reg(CFG_TIME_CONSTANT, t);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_OFFSET, o);
    write_reg(CFG_NL_AMPLITUDE, a);
  endtask

  // load entries at reset settings: time constant zero, unit gain
  task automatic test_reset_load();
    send_pixel(16'h0000, 8'h00);
    send_pixel(16'hFFFF, 8'hFF);
    send_pixel(16'h5555, 8'hAA);
    send_pixel(16'hAAAA, 8'h55);
    for (int i = 0; i < 4; i++) send_pixel(pick_index(), PIX_W'($urandom_range(255)));
    loaded_idx.push_back(0);
    loaded_idx.push_back(16'hFFFF);
    loaded_idx.push_back(16'h5555);
    loaded_idx.push_back(16'hAAAA);
    // unknown register index is ignored
    write_reg(CFG_IDX_W'(4), 20'hFFFFF);
    write_reg(CFG_IDX_W'(255), 20'h00000);
  endtask

  task automatic test_extremes();
    // maximum target: full gain and offset
    set_all(20'h00000, 20'h07FFF, 20'h7FFFF, 20'h00000);
    send_pixel(16'h0000, 8'hFF);
    // minimum target
    write_reg(CFG_OFFSET, 20'h80000);
    send_pixel(16'hFFFF, 8'h00);
    // time constant of one keeps the old value; above one is treated as one
    write_reg(CFG_TIME_CONSTANT, 20'h10000);
    send_pixel(16'h0000, 8'h00);
    write_reg(CFG_TIME_CONSTANT, 20'h1FFFF);
    send_pixel(16'hFFFF, 8'hFF);
    // half blend, then nonlinear at the smallest and largest amplitude
    set_all(20'h08000, 20'h01000, 20'h00000, 20'h00000);
    send_pixel(16'h0000, 8'h80);
    write_reg(CFG_NL_AMPLITUDE, 20'h00001);
    send_pixel(16'h0000, 8'hFF);
    send_pixel(16'hFFFF, 8'h01);
    write_reg(CFG_NL_AMPLITUDE, 20'hFFFFF);
    send_pixel(16'h0000, 8'h00);
    send_pixel(16'h5555, 8'hFF);
    write_reg(CFG_TIME_CONSTANT, 20'h10000);
    send_pixel(16'hAAAA, 8'h7F);
    // gain data with bits above the register width
    set_all(20'h00000, 20'hF8000, 20'h00100, 20'h00000);
    send_pixel(16'h5555, 8'hFF);
    drain();
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] t, a;
    case ($urandom_range(3))
      0: t = '0;
      1: t = 20'h10000;
      2: t = CFG_DATA_W'($urandom_range(131071));
      default: t = CFG_DATA_W'($urandom_range(65535));
    endcase
    case ($urandom_range(3))
      0, 1: a = '0;
      2: a = CFG_DATA_W'($urandom_range(1023));
      default: a = CFG_DATA_W'($urandom_range(1048575));
    endcase
    set_all(t, CFG_DATA_W'($urandom_range(1048575)), CFG_DATA_W'($urandom_range(1048575)),
            a);
  endtask

  task automatic test_random(int idle, int stall, int n_sets, int per_set);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int s = 0; s < n_sets; s++) begin
      random_config();
      for (int i = 0; i < per_set; i++) send_pixel(pick_index(), PIX_W'($urandom()));
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    random_config();
    hold_req = 1;
    for (int i = 0; i < 60; i++) send_pixel(pick_index(), PIX_W'($urandom()));
    // sender waits here for every outstanding beat
    drain();
    for (int i = 0; i < 20; i++) send_pixel(pick_index(), PIX_W'($urandom()));
    drain();
  endtask

  // receiver
  initial begin
    int held;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk_i);
        hold_req = 0;
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    blend_res_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (out_if.saturated) n_sat++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat value=%0d sat=%0b", $time,
                 out_if.filtered_value, out_if.saturated);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.filtered_value !== exp_r.value) begin
          errors++;
          $display("%0t: filtered_value expected %0d actual %0d", $time,
                   exp_r.value, out_if.filtered_value);
        end
        if (out_if.saturated !== exp_r.sat) begin
          errors++;
          $display("%0t: saturated expected %0b actual %0b", $time,
                   exp_r.sat, out_if.saturated);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d beats outstanding", $time, expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    tc_q = '0;
    gain_q = GAIN_RST;
    offset_q = '0;
    amp_q = '0;
    in_if.valid <= 1'b0;
    in_if.pixel_index <= '0;
    in_if.pixel <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_reset_load();
    test_extremes();
    test_random(0, 0, 5, 55);
    test_random(67, 0, 5, 55);
    test_random(0, 67, 5, 55);
    test_random(27, 27, 5, 55);
    test_backpressure();
    test_random(0, 0, 1, 30);
    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d pixels (%0d nonlinear), %0d results, %0d saturated, %0d reg writes,",
             n_pixels, n_nonlinear, n_results, n_sat, n_cfg);
    $display("%0d frame entries, under four idling mixes and one long output hold-off.",
             loaded_idx.size());
    if (errors == 0 && expected_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
